// File: rtl/core/bco_pkg.sv
// bco_pkg: shape codes, pair classes and fixed field widths for the collision block
`timescale 1ns / 1ps

package bco_pkg;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int SIZE_W = 15;
  localparam int OV_W   = 17;
  // extent sums (up to twice a radius sum) fit in this width
  localparam int EXT_W  = 18;
  // gap offsets (a difference of two sizes, or a negated size) as a signed value
  localparam int GADD_W = 17;
  localparam int RAD_W  = 16;

  // shape kind codes
  localparam logic [KIND_W-1:0] SHAPE_CIRCLE = 2'd0;
  localparam logic [KIND_W-1:0] SHAPE_RECT   = 2'd1;

  // pair class, settled in the first stage
  typedef enum logic [1:0] {
    PAIR_NONE = 2'd0,
    PAIR_CC   = 2'd1,
    PAIR_RR   = 2'd2,
    PAIR_CR   = 2'd3
  } pair_cls_t;

endpackage

// File: rtl/core/bbox_collision_overlap.sv
// bbox_collision_overlap: pipelined circle / rectangle collision and overlap test
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------------------
//  s_*      in   one shape pair: kinds, positions and sizes of both shapes
//  m_*      out  one result: colliding flag and per-axis overlap
//
// four register stages, one pair accepted every cycle while the output is not
// stalled; each pair passes through the stages below in order before its
// result is offered on m_*.
// the stages are: difference and class decode, clamp and gap select,
// squaring, then distance compare and overlap. each stage holds its beat
// while the next one is full and stalled, so a stall collapses bubbles and
// never drops or repeats a beat. rst clears the valid bits only.
`timescale 1ns / 1ps

module bbox_collision_overlap
  import bco_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // shape_a, a_x, a_y, a_w, a_h, shape_b, b_x, b_y, b_w, b_h, zero pad
  input  logic [((4 * COORD_BITS + 4 * SIZE_W + 2 * KIND_W + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // colliding, overlap_x, overlap_y, zero pad
  output logic [((1 + 2 * OV_W + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int C      = COORD_BITS;
  localparam int OUT_BITS = 1 + 2 * OV_W;
  localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8;

  // field offsets in s_tdata
  localparam int O_KA = 0;
  localparam int O_AX = O_KA + KIND_W;
  localparam int O_AY = O_AX + C;
  localparam int O_AW = O_AY + C;
  localparam int O_AH = O_AW + SIZE_W;
  localparam int O_KB = O_AH + SIZE_W;
  localparam int O_BX = O_KB + KIND_W;
  localparam int O_BY = O_BX + C;
  localparam int O_BW = O_BY + C;
  localparam int O_BH = O_BW + SIZE_W;

  // working widths: differences, magnitudes, doubled gaps, final overlap
  localparam int W  = ((C > SIZE_W + 1) ? C : SIZE_W + 1) + 2;
  localparam int MW = W - 1;
  localparam int GW = W + 2;
  localparam int OW = GW + 1;
  localparam int DW = 2 * MW + 1;

  // input field split
  logic [KIND_W-1:0] ka, kb;
  logic [C-1:0]      ax, ay, bx, by;
  logic [SIZE_W-1:0] aw, ah, bw, bh;

  assign ka = s_tdata[O_KA +: KIND_W];
  assign ax = s_tdata[O_AX +: C];
  assign ay = s_tdata[O_AY +: C];
  assign aw = s_tdata[O_AW +: SIZE_W];
  assign ah = s_tdata[O_AH +: SIZE_W];
  assign kb = s_tdata[O_KB +: KIND_W];
  assign bx = s_tdata[O_BX +: C];
  assign by = s_tdata[O_BY +: C];
  assign bw = s_tdata[O_BW +: SIZE_W];
  assign bh = s_tdata[O_BH +: SIZE_W];

  // stage load enables, back to front
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  // ---------------------------------------------------------------------
  // stage 1: class decode, circle-first swap, coordinate differences
  // ---------------------------------------------------------------------
  pair_cls_t           cls_next;
  logic                swap;
  logic [C-1:0]        px, py, qx, qy;
  logic [SIZE_W-1:0]   pw, ph, qw, qh;
  logic signed [W-1:0] px_e, py_e, qx_e, qy_e, pw_e, ph_e, qw_e, qh_e;
  logic [RAD_W-1:0]    wsum;
  logic [EXT_W-1:0]    sx_next, sy_next;
  logic [RAD_W-1:0]    rad_next;
  logic signed [GADD_W-1:0] gx_add_next, gy_add_next;

  always_comb begin
    if (ka == SHAPE_CIRCLE && kb == SHAPE_CIRCLE) begin
      cls_next = PAIR_CC;
    end else if (ka == SHAPE_RECT && kb == SHAPE_RECT) begin
      cls_next = PAIR_RR;
    end else if ((ka == SHAPE_CIRCLE && kb == SHAPE_RECT) ||
                 (ka == SHAPE_RECT && kb == SHAPE_CIRCLE)) begin
      cls_next = PAIR_CR;
    end else begin
      cls_next = PAIR_NONE;
    end
  end

  // the circle of a mixed pair always goes to the p side
  assign swap = (ka == SHAPE_RECT) && (kb == SHAPE_CIRCLE);
  assign px = swap ? bx : ax;
  assign py = swap ? by : ay;
  assign pw = swap ? bw : aw;
  assign ph = swap ? bh : ah;
  assign qx = swap ? ax : bx;
  assign qy = swap ? ay : by;
  assign qw = swap ? aw : bw;
  assign qh = swap ? ah : bh;

  assign px_e = {{(W - C){px[C-1]}}, px};
  assign py_e = {{(W - C){py[C-1]}}, py};
  assign qx_e = {{(W - C){qx[C-1]}}, qx};
  assign qy_e = {{(W - C){qy[C-1]}}, qy};
  assign pw_e = {{(W - SIZE_W){1'b0}}, pw};
  assign ph_e = {{(W - SIZE_W){1'b0}}, ph};
  assign qw_e = {{(W - SIZE_W){1'b0}}, qw};
  assign qh_e = {{(W - SIZE_W){1'b0}}, qh};

  assign wsum = {1'b0, pw} + {1'b0, qw};

  // summed extents, squared radius operand and gap offsets per class
  always_comb begin
    case (cls_next)
      PAIR_CC: begin
        sx_next     = {1'b0, wsum, 1'b0};
        sy_next     = {1'b0, wsum, 1'b0};
        rad_next    = wsum;
        gx_add_next = '0;
        gy_add_next = '0;
      end
      PAIR_RR: begin
        sx_next     = {2'b0, wsum};
        sy_next     = {2'b0, ({1'b0, ph} + {1'b0, qh})};
        rad_next    = '0;
        gx_add_next = $signed({2'b0, pw}) - $signed({2'b0, qw});
        gy_add_next = $signed({2'b0, ph}) - $signed({2'b0, qh});
      end
      PAIR_CR: begin
        sx_next     = {2'b0, pw, 1'b0} + {3'b0, qw};
        sy_next     = {2'b0, pw, 1'b0} + {3'b0, qh};
        rad_next    = {1'b0, pw};
        gx_add_next = -$signed({2'b0, qw});
        gy_add_next = -$signed({2'b0, qh});
      end
      default: begin
        sx_next     = '0;
        sy_next     = '0;
        rad_next    = '0;
        gx_add_next = '0;
        gy_add_next = '0;
      end
    endcase
  end

  pair_cls_t           cls1;
  logic signed [W-1:0] dlo_x1, dhi_x1, dup_x1, dlo_y1, dhi_y1, dup_y1;
  logic [EXT_W-1:0]    sx1, sy1;
  logic [RAD_W-1:0]    rad1;
  logic signed [GADD_W-1:0] gx_add1, gy_add1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cls1    <= cls_next;
      dlo_x1  <= px_e - qx_e;
      dhi_x1  <= px_e - qx_e - qw_e;
      dup_x1  <= px_e - qx_e + pw_e;
      dlo_y1  <= py_e - qy_e;
      dhi_y1  <= py_e - qy_e - qh_e;
      dup_y1  <= py_e - qy_e + ph_e;
      sx1     <= sx_next;
      sy1     <= sy_next;
      rad1    <= rad_next;
      gx_add1 <= gx_add_next;
      gy_add1 <= gy_add_next;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: clamp to the rectangle, distance magnitudes, interval test
  // ---------------------------------------------------------------------
  logic signed [W-1:0] dsel_x, dsel_y, dneg_x, dneg_y;
  logic                rr_hit_next;

  always_comb begin
    case (cls1)
      PAIR_CR: begin
        // below the rectangle, above it, or inside
        if (dlo_x1[W-1]) begin
          dsel_x = dlo_x1;
        end else if (!dhi_x1[W-1] && dhi_x1 != '0) begin
          dsel_x = dhi_x1;
        end else begin
          dsel_x = '0;
        end
        if (dlo_y1[W-1]) begin
          dsel_y = dlo_y1;
        end else if (!dhi_y1[W-1] && dhi_y1 != '0) begin
          dsel_y = dhi_y1;
        end else begin
          dsel_y = '0;
        end
      end
      default: begin
        dsel_x = dlo_x1;
        dsel_y = dlo_y1;
      end
    endcase
  end

  assign dneg_x = -dsel_x;
  assign dneg_y = -dsel_y;

  // strict open-interval overlap on both axes
  assign rr_hit_next = (!dup_x1[W-1] && dup_x1 != '0) && dhi_x1[W-1] &&
                       (!dup_y1[W-1] && dup_y1 != '0) && dhi_y1[W-1];

  pair_cls_t            cls2;
  logic [MW-1:0]        mag_x2, mag_y2;
  logic                 rr_hit2;
  logic signed [GW-1:0] g_x2, g_y2;
  logic [EXT_W-1:0]     sx2, sy2;
  logic [RAD_W-1:0]     rad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cls2    <= cls1;
      mag_x2  <= dsel_x[W-1] ? dneg_x[MW-1:0] : dsel_x[MW-1:0];
      mag_y2  <= dsel_y[W-1] ? dneg_y[MW-1:0] : dsel_y[MW-1:0];
      rr_hit2 <= rr_hit_next;
      g_x2    <= {dlo_x1[W-1], dlo_x1, 1'b0} +
                 {{(GW - GADD_W){gx_add1[GADD_W-1]}}, gx_add1};
      g_y2    <= {dlo_y1[W-1], dlo_y1, 1'b0} +
                 {{(GW - GADD_W){gy_add1[GADD_W-1]}}, gy_add1};
      sx2     <= sx1;
      sy2     <= sy1;
      rad2    <= rad1;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: squares and absolute centre gaps
  // ---------------------------------------------------------------------
  logic signed [GW-1:0] gneg_x, gneg_y;

  assign gneg_x = -g_x2;
  assign gneg_y = -g_y2;

  pair_cls_t          cls3;
  logic [2*MW-1:0]    sq_x3, sq_y3;
  logic [2*RAD_W-1:0] radsq3;
  logic               rr_hit3;
  logic [GW-2:0]      ga_x3, ga_y3;
  logic [EXT_W-1:0]   sx3, sy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cls3    <= cls2;
      sq_x3   <= mag_x2 * mag_x2;
      sq_y3   <= mag_y2 * mag_y2;
      radsq3  <= rad2 * rad2;
      rr_hit3 <= rr_hit2;
      ga_x3   <= g_x2[GW-1] ? gneg_x[GW-2:0] : g_x2[GW-2:0];
      ga_y3   <= g_y2[GW-1] ? gneg_y[GW-2:0] : g_y2[GW-2:0];
      sx3     <= sx2;
      sy3     <= sy2;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: distance compare, overlap, output register
  // ---------------------------------------------------------------------
  logic [DW-1:0]        dsq;
  logic                 hit;
  logic signed [OW-1:0] ov_x, ov_y;
  logic [OV_W-1:0]      ovx_next, ovy_next;

  assign dsq = {1'b0, sq_x3} + {1'b0, sq_y3};

  always_comb begin
    case (cls3)
      PAIR_CC, PAIR_CR: hit = dsq <= {{(DW - 2 * RAD_W){1'b0}}, radsq3};
      PAIR_RR:          hit = rr_hit3;
      default:          hit = 1'b0;
    endcase
  end

  assign ov_x = $signed({{(OW - EXT_W){1'b0}}, sx3}) - $signed({2'b0, ga_x3});
  assign ov_y = $signed({{(OW - EXT_W){1'b0}}, sy3}) - $signed({2'b0, ga_y3});

  // zero when apart, never below zero
  assign ovx_next = (hit && !ov_x[OW-1]) ? ov_x[OV_W-1:0] : '0;
  assign ovy_next = (hit && !ov_y[OW-1]) ? ov_y[OV_W-1:0] : '0;

  logic            colliding;
  logic [OV_W-1:0] overlap_x, overlap_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      colliding <= hit;
      overlap_x <= ovx_next;
      overlap_y <= ovy_next;
    end
  end

  // result beat
  assign m_tvalid = v4;
  assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, overlap_y, overlap_x, colliding};

endmodule
